>>> rtl/pfa_pkg.sv
// Shared types and constants of the bitmap page frame allocator.
package pfa_pkg;

  localparam int NUM_PAGES_DEF   = 65536;
  localparam int MAX_REGIONS_DEF = 8;
  localparam int WORD_W          = 64;
  localparam int LOG_W           = 6;
  localparam logic [16:0] TOTAL_MAX = 17'h1FFFF;

  localparam logic [1:0] CMD_CLAIM = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_ADD   = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOSPC  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_SC_REG,
    S_SC_CHK,
    S_SC_LD,
    S_RG_RD,
    S_RG_WR,
    S_DONE
  } state_t;

endpackage

>>> rtl/bitmap_page_frame_allocator.sv
// Top level of the next-fit bitmap page frame allocator.
// Free and add-region read and rewrite each 64-page bitmap word they touch, one word after another.
// Claim scans one page per cycle while the page's bitmap word is held, reading each new word first
// and stepping region by region, then marks the claimed run word by word; a failed first pass repeats from 0.
// One item at a time; in_tready is high only while the sequencer is idle.
// After reset a clearing pass marks every page used.
module bitmap_page_frame_allocator #(
  parameter int NUM_PAGES   = pfa_pkg::NUM_PAGES_DEF,
  parameter int MAX_REGIONS = pfa_pkg::MAX_REGIONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // cmd[1:0], page[17:2], count[34:18], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status[1:0], start_page[17:2], pages_in_use[34:18], pad
);

  localparam int WW    = pfa_pkg::WORD_W;
  localparam int LW    = pfa_pkg::LOG_W;
  localparam int DEPTH = (NUM_PAGES + WW - 1) / WW;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW0   = $clog2(NUM_PAGES + 1);
  localparam int IW    = ((PW0 > 17) ? PW0 : 17) + 1;
  localparam int RIW   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int RCW   = $clog2(MAX_REGIONS + 1);
  localparam logic [IW-1:0] NP = IW'(NUM_PAGES);

  pfa_pkg::state_t state_r, state_nxt;
  logic [1:0]    cmd_r, cmd_nxt;
  logic [15:0]   page_r, page_nxt;
  logic [16:0]   count_r, count_nxt;
  logic          pass_r, pass_nxt;
  logic [RCW-1:0] ri_r, ri_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [16:0]   found_r, found_nxt;
  logic [IW-1:0] end_r, end_nxt;
  logic [IW-1:0] rgp_r, rgp_nxt;
  logic [IW-1:0] rge_r, rge_nxt;
  logic          rgv_r, rgv_nxt;
  logic [WW-1:0] word_r, word_nxt;
  logic [AW-1:0] wtag_r, wtag_nxt;
  logic          wvld_r, wvld_nxt;
  logic [15:0]   cursor_r, cursor_nxt;
  logic [16:0]   inuse_r, inuse_nxt;
  logic [RCW-1:0] rcount_r, rcount_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [15:0]   start_r, start_nxt;
  logic          ov_r, ov_nxt;
  logic [1:0]    ostat_r, ostat_nxt;
  logic [15:0]   ostart_r, ostart_nxt;
  logic [16:0]   ouse_r, ouse_nxt;
  logic [15:0]   base_r [MAX_REGIONS];
  logic [16:0]   len_r  [MAX_REGIONS];
  logic          tbl_we;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [WW-1:0] ram_wdata, ram_rdata;

  pfa_ram #(.W(WW), .D(DEPTH), .AW(AW)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [IW-1:0] rbase, rend, wbase, rem, sum18, s_page;
  logic [WW-1:0] mask, ones;
  logic [16:0]   f_inc;
  logic [17:0]   add_sum;

  function automatic logic [IW-1:0] nend_in(input logic [15:0] p, input logic [16:0] c);
    logic [IW-1:0] e;
    e = IW'(p) + IW'(c);
    if (e > NP) begin
      e = NP;
    end
    return e;
  endfunction

  always_comb begin
    ones    = '1;
    rbase   = IW'(base_r[ri_r[RIW-1:0]]);
    rend    = rbase + IW'(len_r[ri_r[RIW-1:0]]);
    if (rend > NP) begin
      rend = NP;
    end
    wbase   = {rgp_r[IW-1:LW], {LW{1'b0}}};
    rem     = rge_r - wbase;
    mask    = ones << rgp_r[LW-1:0];
    if (rem < IW'(WW)) begin
      mask  = mask & ~(ones << rem[LW-1:0]);
    end
    sum18   = idx_r + IW'(1);
    s_page  = sum18 - IW'(count_r);
    f_inc   = found_r + 17'd1;
    add_sum = {1'b0, inuse_r} + {1'b0, count_r};
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    page_nxt   = page_r;
    count_nxt  = count_r;
    pass_nxt   = pass_r;
    ri_nxt     = ri_r;
    idx_nxt    = idx_r;
    found_nxt  = found_r;
    end_nxt    = end_r;
    rgp_nxt    = rgp_r;
    rge_nxt    = rge_r;
    rgv_nxt    = rgv_r;
    word_nxt   = word_r;
    wtag_nxt   = wtag_r;
    wvld_nxt   = wvld_r;
    cursor_nxt = cursor_r;
    inuse_nxt  = inuse_r;
    rcount_nxt = rcount_r;
    clr_nxt    = clr_r;
    status_nxt = status_r;
    start_nxt  = start_r;
    ov_nxt     = ov_r & ~out_tready;
    ostat_nxt  = ostat_r;
    ostart_nxt = ostart_r;
    ouse_nxt   = ouse_r;
    tbl_we     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = clr_r;
    ram_wdata  = ones;
    ram_raddr  = idx_r[AW+LW-1:LW];
    in_tready  = 1'b0;

    case (state_r)
      pfa_pkg::S_CLR: begin
        ram_we  = 1'b1;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = pfa_pkg::S_IDLE;
        end
      end
      pfa_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_nxt    = in_tdata[1:0];
          page_nxt   = in_tdata[17:2];
          count_nxt  = in_tdata[34:18];
          status_nxt = pfa_pkg::ST_OK;
          start_nxt  = '0;
          case (in_tdata[1:0])
            pfa_pkg::CMD_CLAIM: begin
              if (in_tdata[34:18] == 17'd0) begin
                status_nxt = pfa_pkg::ST_NOSPC;
                state_nxt  = pfa_pkg::S_DONE;
              end else begin
                idx_nxt   = IW'(cursor_r);
                found_nxt = '0;
                ri_nxt    = '0;
                pass_nxt  = 1'b0;
                wvld_nxt  = 1'b0;
                state_nxt = pfa_pkg::S_SC_REG;
              end
            end
            pfa_pkg::CMD_FREE, pfa_pkg::CMD_ADD: begin
              state_nxt = pfa_pkg::S_RG_RD;
              if (in_tdata[1:0] == pfa_pkg::CMD_ADD && rcount_r >= RCW'(MAX_REGIONS)) begin
                status_nxt = pfa_pkg::ST_FULL;
                state_nxt  = pfa_pkg::S_DONE;
              end
            end
            default: begin
              state_nxt = pfa_pkg::S_DONE;
            end
          endcase
        end
      end
      pfa_pkg::S_SC_REG: begin
        if (ri_r >= rcount_r) begin
          if (!pass_r) begin
            cursor_nxt = '0;
            pass_nxt   = 1'b1;
            idx_nxt    = '0;
            found_nxt  = '0;
            ri_nxt     = '0;
          end else begin
            status_nxt = pfa_pkg::ST_NOSPC;
            start_nxt  = '0;
            state_nxt  = pfa_pkg::S_DONE;
          end
        end else begin
          end_nxt = rend;
          if (rbase > idx_r) begin
            idx_nxt   = rbase;
            found_nxt = '0;
          end
          state_nxt = pfa_pkg::S_SC_CHK;
        end
      end
      pfa_pkg::S_SC_CHK: begin
        if (idx_r >= end_r) begin
          ri_nxt    = ri_r + RCW'(1);
          state_nxt = pfa_pkg::S_SC_REG;
        end else if (!wvld_r || wtag_r != idx_r[AW+LW-1:LW]) begin
          state_nxt = pfa_pkg::S_SC_LD;
        end else if (!word_r[idx_r[LW-1:0]]) begin
          if (f_inc == count_r) begin
            // Run complete: mark it used and leave the cursor on its last page.
            rgp_nxt    = s_page;
            rge_nxt    = sum18;
            rgv_nxt    = 1'b1;
            cursor_nxt = idx_r[15:0];
            start_nxt  = s_page[15:0];
            state_nxt  = pfa_pkg::S_RG_RD;
          end else begin
            found_nxt = f_inc;
            idx_nxt   = sum18;
          end
        end else begin
          found_nxt = '0;
          idx_nxt   = sum18;
        end
      end
      pfa_pkg::S_SC_LD: begin
        word_nxt  = ram_rdata;
        wtag_nxt  = idx_r[AW+LW-1:LW];
        wvld_nxt  = 1'b1;
        state_nxt = pfa_pkg::S_SC_CHK;
      end
      pfa_pkg::S_RG_RD: begin
        ram_raddr = rgp_r[AW+LW-1:LW];
        if (rgp_r < rge_r) begin
          state_nxt = pfa_pkg::S_RG_WR;
        end else begin
          state_nxt = pfa_pkg::S_DONE;
          case (cmd_r)
            pfa_pkg::CMD_CLAIM: begin
              inuse_nxt = add_sum[17] ? pfa_pkg::TOTAL_MAX : add_sum[16:0];
            end
            pfa_pkg::CMD_FREE: begin
              inuse_nxt = (inuse_r > count_r) ? inuse_r - count_r : 17'd0;
            end
            default: begin
              tbl_we     = 1'b1;
              rcount_nxt = rcount_r + RCW'(1);
            end
          endcase
        end
      end
      pfa_pkg::S_RG_WR: begin
        ram_we    = 1'b1;
        ram_waddr = rgp_r[AW+LW-1:LW];
        ram_wdata = rgv_r ? (ram_rdata | mask) : (ram_rdata & ~mask);
        rgp_nxt   = wbase + IW'(WW);
        state_nxt = pfa_pkg::S_RG_RD;
      end
      pfa_pkg::S_DONE: begin
        if (!ov_r || out_tready) begin
          ov_nxt     = 1'b1;
          ostat_nxt  = status_r;
          ostart_nxt = start_r;
          ouse_nxt   = inuse_r;
          state_nxt  = pfa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pfa_pkg::S_IDLE;
      end
    endcase

    // Free and add-region both clear the range given by the item, unless add-region is refused for a full table.
    if (state_r == pfa_pkg::S_IDLE && in_tvalid) begin
      rgp_nxt = IW'(in_tdata[17:2]);
      rge_nxt = nend_in(in_tdata[17:2], in_tdata[34:18]);
      rgv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pfa_pkg::S_CLR;
      clr_r    <= '0;
      cursor_r <= '0;
      inuse_r  <= '0;
      rcount_r <= '0;
      ov_r     <= 1'b0;
      wvld_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      cursor_r <= cursor_nxt;
      inuse_r  <= inuse_nxt;
      rcount_r <= rcount_nxt;
      ov_r     <= ov_nxt;
      wvld_r   <= wvld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    page_r   <= page_nxt;
    count_r  <= count_nxt;
    pass_r   <= pass_nxt;
    ri_r     <= ri_nxt;
    idx_r    <= idx_nxt;
    found_r  <= found_nxt;
    end_r    <= end_nxt;
    rgp_r    <= rgp_nxt;
    rge_r    <= rge_nxt;
    rgv_r    <= rgv_nxt;
    word_r   <= word_nxt;
    wtag_r   <= wtag_nxt;
    status_r <= status_nxt;
    start_r  <= start_nxt;
    ostat_r  <= ostat_nxt;
    ostart_r <= ostart_nxt;
    ouse_r   <= ouse_nxt;
    if (tbl_we) begin
      base_r[rcount_r[RIW-1:0]] <= page_r;
      len_r[rcount_r[RIW-1:0]]  <= count_r;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {5'd0, ouse_r, ostart_r, ostat_r};

  a_use_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pfa_pkg::S_SC_CHK) |=> $stable(inuse_r))
    else $error("in-use count changed during a scan");
  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pfa_pkg::S_SC_CHK) |-> (found_r < count_r))
    else $error("run length reached the claim count without completing");
  a_ramwe: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == pfa_pkg::S_CLR || state_r == pfa_pkg::S_RG_WR))
    else $error("bitmap written outside a clear or update step");
  a_rcount: assert property (@(posedge clk) disable iff (!rst_n)
    rcount_r <= RCW'(MAX_REGIONS))
    else $error("region count beyond table size");

endmodule

>>> rtl/pfa_ram.sv
// Generic simple dual-port RAM with registered read data.
module pfa_ram #(
  parameter int W = 64,
  parameter int D = 1024,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sim/bitmap_page_frame_allocator_tb.sv
// Self-checking testbench of the bitmap page frame allocator: directed table, then random items.
module bitmap_page_frame_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPAGES = 65536;
  localparam int NREG   = 8;
  localparam int N_RAND = 800;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [16:0] pages_in_use;
    logic [15:0] start_page;
    logic [1:0]  status;
  } alloc_result_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] page;
    logic [16:0] count;
    bit          typed;
    alloc_result_t want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata;

  bitmap_page_frame_allocator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the allocator state.
  bit          used_map [NPAGES];
  logic [15:0] reg_base [NREG];
  logic [16:0] reg_len  [NREG];
  int          reg_cnt;
  int          cursor;
  int          in_use;

  alloc_result_t pending_results[$];
  int  mismatches = 0;
  int  stall_cnt = 0;

  function automatic bit find_run(input int from, input int n, output int start);
    int idx, found, fin;
    idx = from;
    found = 0;
    for (int r = 0; r < reg_cnt; r++) begin
      fin = int'(reg_base[r]) + int'(reg_len[r]);
      if (fin > NPAGES) fin = NPAGES;
      if (int'(reg_base[r]) > idx) begin
        idx = int'(reg_base[r]);
        found = 0;
      end
      while (idx < fin) begin
        if (!used_map[idx]) begin
          found++;
          if (found == n) begin
            start = idx + 1 - n;
            for (int j = start; j <= idx; j++) used_map[j] = 1'b1;
            cursor = idx & 16'hFFFF;
            return 1'b1;
          end
        end else begin
          found = 0;
        end
        idx++;
      end
    end
    return 1'b0;
  endfunction

  function automatic void release_pages(input int first, input int n);
    for (int i = 0; i < n; i++)
      if (first + i < NPAGES) used_map[first + i] = 1'b0;
  endfunction

  function automatic alloc_result_t allocate(input logic [1:0] cmd, input logic [15:0] page,
                                             input logic [16:0] count);
    alloc_result_t res;
    int start;
    bit ok;
    res = '0;
    start = 0;
    if (cmd == pfa_pkg::CMD_CLAIM) begin
      ok = 1'b0;
      if (count != 0) begin
        ok = find_run(cursor, int'(count), start);
        if (!ok) begin
          cursor = 0;
          ok = find_run(0, int'(count), start);
        end
      end
      if (ok) begin
        in_use += int'(count);
        if (in_use > 17'h1FFFF) in_use = 17'h1FFFF;
        res.start_page = start[15:0];
      end else begin
        res.status = pfa_pkg::ST_NOSPC;
      end
    end else if (cmd == pfa_pkg::CMD_FREE) begin
      release_pages(int'(page), int'(count));
      in_use = (in_use > int'(count)) ? in_use - int'(count) : 0;
    end else if (cmd == pfa_pkg::CMD_ADD) begin
      if (reg_cnt >= NREG) begin
        res.status = pfa_pkg::ST_FULL;
      end else begin
        release_pages(int'(page), int'(count));
        reg_base[reg_cnt] = page;
        reg_len[reg_cnt] = count;
        reg_cnt++;
      end
    end
    res.pages_in_use = in_use[16:0];
    return res;
  endfunction

  function automatic int short_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
           (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3));
  endfunction

  // The valid stays high across a zero gap, so the next item follows at once.
  task automatic send_item(input logic [1:0] cmd, input logic [15:0] page,
                           input logic [16:0] count, input bit typed,
                           input alloc_result_t want);
    alloc_result_t pred;
    int gap;
    gap = short_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pred = allocate(cmd, page, count);
    if (typed && pred !== want)
      $display("table row disagrees with predictor: %h vs %h", want, pred);
    pending_results.push_back(typed ? want : pred);
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, count, page, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Result side: random back-pressure and field-by-field comparison.
  always @(posedge clk) begin
    alloc_result_t got, exp_r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[34:0];
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          exp_r = pending_results.pop_front();
          if (got.status !== exp_r.status || got.start_page !== exp_r.start_page ||
              got.pages_in_use !== exp_r.pages_in_use) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: status %0d/%0d start %0d/%0d in_use %0d/%0d (exp/got)",
                       exp_r.status, got.status, exp_r.start_page, got.start_page,
                       exp_r.pages_in_use, got.pages_in_use);
          end
        end
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 49) == 0) begin
        stall_cnt = $urandom_range(10, 60);
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 9) < 7);
      end
    end
  end

  directed_row_t table_rows[$];

  function automatic void add_row(input logic [1:0] cmd, input logic [15:0] page,
                                  input logic [16:0] count, input bit typed,
                                  input logic [1:0] st, input logic [15:0] sp,
                                  input logic [16:0] piu);
    directed_row_t row;
    row.cmd = cmd; row.page = page; row.count = count; row.typed = typed;
    row.want = '{piu, sp, st};
    table_rows.push_back(row);
  endfunction

  initial begin
    int cmd_pick, rsel;
    logic [15:0] pg;
    logic [16:0] cnt;
    for (int i = 0; i < NPAGES; i++) used_map[i] = 1'b1;
    reg_cnt = 0; cursor = 0; in_use = 0;

    // Everything used after reset, so early claims fail.
    add_row(pfa_pkg::CMD_CLAIM, 16'd0, 17'd1, 1'b1, pfa_pkg::ST_NOSPC, 16'd0, 17'd0);
    add_row(pfa_pkg::CMD_CLAIM, 16'd0, 17'd0, 1'b1, pfa_pkg::ST_NOSPC, 16'd0, 17'd0);
    add_row(pfa_pkg::CMD_FREE, 16'd0, 17'd0, 1'b1, pfa_pkg::ST_OK, 16'd0, 17'd0);
    add_row(CMD_UNUSED, 16'hFFFF, 17'h1FFFF, 1'b1, pfa_pkg::ST_OK, 16'd0, 17'd0);
    add_row(pfa_pkg::CMD_ADD, 16'd100, 17'd50, 1'b1, pfa_pkg::ST_OK, 16'd0, 17'd0);
    add_row(pfa_pkg::CMD_CLAIM, 16'd0, 17'd10, 1'b1, pfa_pkg::ST_OK, 16'd100, 17'd10);
    add_row(pfa_pkg::CMD_CLAIM, 16'd0, 17'd45, 0, 0, 0, 0);
    add_row(pfa_pkg::CMD_CLAIM, 16'd0, 17'd20, 0, 0, 0, 0);
    add_row(pfa_pkg::CMD_ADD, 16'd150, 17'd30, 0, 0, 0, 0);
    add_row(pfa_pkg::CMD_CLAIM, 16'd0, 17'd25, 0, 0, 0, 0);
    add_row(pfa_pkg::CMD_ADD, 16'd300, 17'd40, 0, 0, 0, 0);
    add_row(pfa_pkg::CMD_CLAIM, 16'd0, 17'd35, 0, 0, 0, 0);
    add_row(pfa_pkg::CMD_ADD, 16'hFFC0, 17'h1FFFF, 0, 0, 0, 0);
    add_row(pfa_pkg::CMD_CLAIM, 16'd0, 17'd64, 0, 0, 0, 0);
    add_row(pfa_pkg::CMD_FREE, 16'd100, 17'd200, 0, 0, 0, 0);
    add_row(pfa_pkg::CMD_FREE, 16'hFFFF, 17'h1FFFF, 0, 0, 0, 0);
    add_row(pfa_pkg::CMD_ADD, 16'd2000, 17'd500, 0, 0, 0, 0);
    add_row(pfa_pkg::CMD_ADD, 16'd1000, 17'd300, 0, 0, 0, 0);
    add_row(pfa_pkg::CMD_ADD, 16'd4000, 17'd300, 0, 0, 0, 0);
    add_row(pfa_pkg::CMD_ADD, 16'd0, 17'd64, 0, 0, 0, 0);
    add_row(pfa_pkg::CMD_ADD, 16'd5000, 17'd10, 1'b1, pfa_pkg::ST_FULL, 16'd0, 17'd0);
    add_row(pfa_pkg::CMD_CLAIM, 16'd0, 17'd1000, 0, 0, 0, 0);
    add_row(pfa_pkg::CMD_CLAIM, 16'd0, 17'd7, 0, 0, 0, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (table_rows[i])
      send_item(table_rows[i].cmd, table_rows[i].page, table_rows[i].count,
                table_rows[i].typed, table_rows[i].want);

    // Most random items stay near the region bases and ask for short runs, so that most searches stay short.
    for (int n = 0; n < N_RAND; n++) begin
      cmd_pick = $urandom_range(0, 99);
      rsel = $urandom_range(0, NREG - 1);
      pg = 16'(int'(reg_base[rsel]) + int'($urandom_range(0, 400)));
      cnt = 17'($urandom_range(0, 40));
      if (cmd_pick < 5) begin
        pg = 16'($urandom);
        cnt = 17'($urandom_range(0, 17'h1FFFF));
        if ($urandom_range(0, 1)) pg = 16'(16'hFFFF - $urandom_range(0, 70));
        send_item($urandom_range(0, 1) ? pfa_pkg::CMD_FREE : CMD_UNUSED, pg, cnt, 1'b0, '0);
      end else if (cmd_pick < 10) begin
        send_item(pfa_pkg::CMD_CLAIM, 16'd0,
                  $urandom_range(0, 1) ? 17'd0 : 17'($urandom), 1'b0, '0);
      end else if (cmd_pick < 60) begin
        send_item(pfa_pkg::CMD_CLAIM, 16'($urandom), cnt, 1'b0, '0);
      end else begin
        send_item(pfa_pkg::CMD_FREE, pg, cnt, 1'b0, '0);
      end
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Verification failed");
    $finish;
  end

endmodule
